// ===== hdl/otl_pkg.sv =====
`timescale 1ns / 1ps

package otl_pkg;

    localparam int TIMER_SLOTS_DEF = 16;

    localparam int CMD_W   = 2;
    localparam int DELAY_W = 24;
    localparam int ID_W    = 32;
    localparam int STAT_W  = 2;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SET    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic KIND_FIRED  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    typedef struct packed {
        logic [ID_W-1:0]    ident;
        logic [DELAY_W-1:0] remaining;
    } t_slot;

endpackage

// ===== hdl/otl_cmd_if.sv =====
`timescale 1ns / 1ps

interface otl_cmd_if
    import otl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [DELAY_W-1:0] delay_ms;
    logic [ID_W-1:0]    timer_id;

    modport source (output valid, output command, output delay_ms, output timer_id,
                    input ready);
    modport sink (input valid, input command, input delay_ms, input timer_id,
                  output ready);
endinterface

// ===== hdl/otl_res_if.sv =====
`timescale 1ns / 1ps

interface otl_res_if
    import otl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [ID_W-1:0]    fired_id;
    logic [DELAY_W-1:0] next_timeout;
    logic               none_pending;
    logic [STAT_W-1:0]  status;
    logic               last;

    modport source (output valid, output kind, output fired_id, output next_timeout,
                    output none_pending, output status, output last, input ready);
    modport sink (input valid, input kind, input fired_id, input next_timeout,
                  input none_pending, input status, input last, output ready);
endinterface

// ===== hdl/otl_slot_mem.sv =====
`timescale 1ns / 1ps

module otl_slot_mem
    import otl_pkg::*;
#(
    parameter int DEPTH = TIMER_SLOTS_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_slot         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_slot         o_rdata
);

    t_slot r_mem [DEPTH];
    t_slot r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/one_shot_timer_list_core.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Contents
// i_cmd     in         command, delay_ms, timer_id
// o_res     out        kind, fired_id, next_timeout, none_pending, status, last
//
// A command goes through these steps in order: accept, start the slot memory read,
// one step per stored timer for the compacting read-modify-write pass over the
// slot memory, then the status result.
// A command other than a set on an empty list skips the pass.
// Every scan step and the status result wait while the output register is full and
// o_res.ready stays low.
// Reset (synchronous, active low) empties the list at once; slot contents need no clear.

module one_shot_timer_list_core
    import otl_pkg::*;
#(
    parameter int TIMER_SLOTS = TIMER_SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    otl_cmd_if.sink   i_cmd,
    otl_res_if.source o_res
);

    localparam int AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CW = $clog2(TIMER_SLOTS + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_EVAL = 4'b0100,
        S_STAT = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_wr, n_wr;
    logic [CMD_W-1:0] r_cmd, n_cmd;
    logic [ID_W-1:0]  r_id, n_id;
    logic             r_full, n_full;
    logic             r_found, n_found;
    logic             r_have, n_have;
    logic [DELAY_W-1:0] r_least, n_least;

    logic               r_out_valid, n_out_valid;
    logic               r_kind, n_kind;
    logic [ID_W-1:0]    r_fired_id, n_fired_id;
    logic [DELAY_W-1:0] r_next_timeout, n_next_timeout;
    logic               r_none_pending, n_none_pending;
    logic [STAT_W-1:0]  r_status, n_status;
    logic               r_last, n_last;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_slot         mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    t_slot         mem_rdata;

    logic               accept;
    logic               out_free;
    logic               is_full;
    logic [DELAY_W-1:0] rem_new;
    logic               del_hit;
    logic               last_entry;

    otl_slot_mem #(
        .DEPTH (TIMER_SLOTS),
        .AW    (AW)
    ) u_slot_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && (r_state == S_IDLE);
    assign out_free    = !r_out_valid || o_res.ready;
    assign is_full     = (r_count == CW'(TIMER_SLOTS));

    assign rem_new    = ((r_cmd == CMD_TICK) && (mem_rdata.remaining != '0))
                      ? (mem_rdata.remaining - DELAY_W'(1)) : mem_rdata.remaining;
    assign del_hit    = (r_cmd == CMD_DELETE) && !r_found && (mem_rdata.ident == r_id);
    assign last_entry = ((r_rd + CW'(1)) == r_count);

    always_comb begin
        n_state        = r_state;
        n_count        = r_count;
        n_rd           = r_rd;
        n_wr           = r_wr;
        n_cmd          = r_cmd;
        n_id           = r_id;
        n_full         = r_full;
        n_found        = r_found;
        n_have         = r_have;
        n_least        = r_least;
        n_out_valid    = r_out_valid && !o_res.ready;
        n_kind         = r_kind;
        n_fired_id     = r_fired_id;
        n_next_timeout = r_next_timeout;
        n_none_pending = r_none_pending;
        n_status       = r_status;
        n_last         = r_last;

        mem_we    = 1'b0;
        mem_waddr = r_wr[AW-1:0];
        mem_wdata = '{ident: mem_rdata.ident, remaining: rem_new};
        mem_re    = 1'b0;
        mem_raddr = r_rd[AW-1:0];

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd   = i_cmd.command;
                    n_id    = i_cmd.timer_id;
                    n_full  = (i_cmd.command == CMD_SET) && is_full;
                    n_found = 1'b0;
                    n_have  = 1'b0;
                    n_least = '0;
                    n_rd    = '0;
                    n_wr    = '0;
                    if ((i_cmd.command == CMD_SET) && !is_full) begin
                        // append at the tail, then scan
                        mem_we    = 1'b1;
                        mem_waddr = r_count[AW-1:0];
                        mem_wdata = '{ident: i_cmd.timer_id, remaining: i_cmd.delay_ms};
                        n_count   = r_count + CW'(1);
                        n_state   = S_READ;
                    end else if (r_count == '0) begin
                        n_state = S_STAT;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                mem_re  = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (out_free) begin
                    if (del_hit) begin
                        n_found = 1'b1;
                    end else if (rem_new == '0) begin
                        n_out_valid    = 1'b1;
                        n_kind         = KIND_FIRED;
                        n_fired_id     = mem_rdata.ident;
                        n_next_timeout = '0;
                        n_none_pending = 1'b0;
                        n_status       = STATUS_OK;
                        n_last         = 1'b0;
                    end else begin
                        // keep the entry, closing any gap left by dropped ones
                        mem_we  = 1'b1;
                        n_wr    = r_wr + CW'(1);
                        n_have  = 1'b1;
                        if (!r_have || (rem_new < r_least)) begin
                            n_least = rem_new;
                        end
                    end
                    if (last_entry) begin
                        n_count = n_wr;
                        n_state = S_STAT;
                    end else begin
                        n_rd      = r_rd + CW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = n_rd[AW-1:0];
                    end
                end
            end
            S_STAT: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_kind         = KIND_STATUS;
                    n_fired_id     = '0;
                    n_next_timeout = r_have ? r_least : '0;
                    n_none_pending = !r_have;
                    if (r_full) begin
                        n_status = STATUS_FULL;
                    end else if ((r_cmd == CMD_DELETE) && !r_found) begin
                        n_status = STATUS_NOT_FOUND;
                    end else begin
                        n_status = STATUS_OK;
                    end
                    n_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd           <= n_rd;
        r_wr           <= n_wr;
        r_cmd          <= n_cmd;
        r_id           <= n_id;
        r_full         <= n_full;
        r_found        <= n_found;
        r_have         <= n_have;
        r_least        <= n_least;
        r_kind         <= n_kind;
        r_fired_id     <= n_fired_id;
        r_next_timeout <= n_next_timeout;
        r_none_pending <= n_none_pending;
        r_status       <= n_status;
        r_last         <= n_last;
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_kind;
    assign o_res.fired_id     = r_fired_id;
    assign o_res.next_timeout = r_next_timeout;
    assign o_res.none_pending = r_none_pending;
    assign o_res.status       = r_status;
    assign o_res.last         = r_last;

endmodule
